// ===== hdl/rrr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the register rename / reorder buffer core.
// No dependencies; the other files that use it refer to it by scoped names.
package rrr_pkg;

    localparam int REG_W    = 7;   // architectural register field
    localparam int TAG_W    = 6;   // tag fields on the stream ports
    localparam int FUNC_W   = 2;
    localparam int RW_W     = 4;   // retire_width register
    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 32;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 40;

    localparam logic            CFG_IDX_RETIRE_WIDTH = 1'b0;
    localparam logic [RW_W-1:0] RETIRE_WIDTH_RST     = 4'd1;

    // map table lookup slots
    localparam int LK_SRC1 = 0;
    localparam int LK_SRC2 = 1;
    localparam int LK_DEST = 2;
    localparam int LK_N    = 3;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_RENAME    = 2'd0,
        FUNC_WRITEBACK = 2'd1,
        FUNC_RETIRE    = 2'd2
    } t_func;

    typedef logic [REG_W-1:0] t_reg;
    typedef logic [TAG_W-1:0] t_tag;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        t_reg              dest_reg;
        logic              dest_present;
        t_reg              src1_reg;
        logic              src1_present;
        t_reg              src2_reg;
        logic              src2_present;
        t_tag              done_tag;
    } t_in_item;

    typedef struct packed {
        logic accepted;
        t_tag alloc_tag;
        logic src1_from_rob;
        t_reg src1_name;
        logic src1_ready;
        logic src2_from_rob;
        t_reg src2_name;
        logic src2_ready;
        t_tag retired_tag;
        t_reg retired_dest;
        logic retired_has_dest;
        logic last;
    } t_out_item;

    typedef struct packed {
        logic                       load;
        logic [LK_N-1:0][REG_W-1:0] regs;
    } t_map_lookup;

    typedef struct packed {
        logic set;
        t_reg set_reg;
        logic clr;
        t_reg clr_reg;
    } t_map_update;

endpackage

// ===== hdl/rrr_ram.sv =====
`timescale 1ns / 1ps
// Generic RAM: one write port, N_RD read ports, registered read data.
// Standalone; no package dependencies.
module rrr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int N_RD  = 1
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr [N_RD],
    output logic [WIDTH-1:0]         o_rdata [N_RD]
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            for (int k = 0; k < N_RD; k++) begin
                o_rdata[k] <= r_mem[i_raddr[k]];
            end
        end
    end

endmodule

// ===== hdl/rrr_map.sv =====
`timescale 1ns / 1ps
// Rename map table: per-register valid flops plus tag RAMs, read when an item is loaded.
// Depends on rrr_pkg and rrr_ram.
module rrr_map #(
    parameter int ARCH_REGS = 67,
    parameter int ROB_DEPTH = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  rrr_pkg::t_map_lookup         i_lookup,
    input  rrr_pkg::t_map_update         i_update,
    input  logic [$clog2(ROB_DEPTH)-1:0] i_set_tag,
    output logic [rrr_pkg::LK_N-1:0]     o_hit,
    output logic [$clog2(ROB_DEPTH)-1:0] o_tag [rrr_pkg::LK_N]
);

    localparam int AW = $clog2(ARCH_REGS);
    localparam int TW = $clog2(ROB_DEPTH);

    logic [ARCH_REGS-1:0]     r_valid;
    rrr_pkg::t_reg            r_reg [rrr_pkg::LK_N];
    logic [rrr_pkg::LK_N-1:0] r_fwd;
    logic [TW-1:0]            r_fwd_tag;

    logic [AW-1:0] ra_src [2];
    logic [AW-1:0] ra_dst [1];
    logic [TW-1:0] rd_src [2];
    logic [TW-1:0] rd_dst [1];
    logic [TW-1:0] raw    [rrr_pkg::LK_N];

    assign ra_src[0] = AW'(i_lookup.regs[rrr_pkg::LK_SRC1]);
    assign ra_src[1] = AW'(i_lookup.regs[rrr_pkg::LK_SRC2]);
    assign ra_dst[0] = AW'(i_lookup.regs[rrr_pkg::LK_DEST]);

    // source copy: two read ports
    rrr_ram #(.WIDTH(TW), .DEPTH(ARCH_REGS), .N_RD(2)) u_ram_src (
        .i_clk   (i_clk),
        .i_we    (i_update.set),
        .i_waddr (AW'(i_update.set_reg)),
        .i_wdata (i_set_tag),
        .i_re    (i_lookup.load),
        .i_raddr (ra_src),
        .o_rdata (rd_src)
    );

    // destination copy: previous mapping of the renamed register
    rrr_ram #(.WIDTH(TW), .DEPTH(ARCH_REGS), .N_RD(1)) u_ram_dst (
        .i_clk   (i_clk),
        .i_we    (i_update.set),
        .i_waddr (AW'(i_update.set_reg)),
        .i_wdata (i_set_tag),
        .i_re    (i_lookup.load),
        .i_raddr (ra_dst),
        .o_rdata (rd_dst)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (i_update.set) begin
                r_valid[AW'(i_update.set_reg)] <= 1'b1;
            end
            if (i_update.clr) begin
                r_valid[AW'(i_update.clr_reg)] <= 1'b0;
            end
        end
    end

    // Capture addresses with the read; forward a write landing on the same edge.
    always_ff @(posedge i_clk) begin
        if (i_lookup.load) begin
            for (int k = 0; k < rrr_pkg::LK_N; k++) begin
                r_reg[k] <= i_lookup.regs[k];
                r_fwd[k] <= i_update.set && (i_update.set_reg == i_lookup.regs[k]);
            end
            r_fwd_tag <= i_set_tag;
        end
    end

    always_comb begin
        raw[rrr_pkg::LK_SRC1] = rd_src[0];
        raw[rrr_pkg::LK_SRC2] = rd_src[1];
        raw[rrr_pkg::LK_DEST] = rd_dst[0];
        for (int k = 0; k < rrr_pkg::LK_N; k++) begin
            o_hit[k] = (32'(r_reg[k]) < ARCH_REGS) && r_valid[AW'(r_reg[k])];
            o_tag[k] = r_fwd[k] ? r_fwd_tag : raw[k];
        end
    end

endmodule

// ===== hdl/register_rename_rob_core.sv =====
`timescale 1ns / 1ps
// Top level of the register rename unit with map table and circular reorder buffer.
// Depends on rrr_pkg, rrr_map and rrr_ram.
//
// Usage
//   Items enter on the s_axis channel: tuser carries the function (rename, writeback,
//   retire), tdata the register and tag fields. Results leave on m_axis, one per
//   transfer, with tlast on the final result of an item. retire_width is set over
//   the APB port (register 0, byte address 0) while the block is idle.
//   An accepted item sits in the input register and executes in the first cycle
//   that the output register is free (a writeback does not wait); its result is
//   presented from the output register the cycle after. Rename and writeback
//   complete as they execute, so one item a cycle is sustained while m_axis
//   does not stall. A retire item commits up to min(retire_width, MAX_RETIRE)
//   ready entries from the head, one result each (one result per cycle while
//   m_axis does not stall), possibly none. A writeback item produces no result.
//   Reset empties the buffer and map table and sets retire_width to 1; no
//   clearing pass is needed. When m_axis stalls, the output register holds, a
//   rename or retire item in the input register waits and s_axis tready drops;
//   a writeback in the input register still completes.
module register_rename_rob_core #(
    parameter int ROB_DEPTH  = 64,
    parameter int ARCH_REGS  = 67,
    parameter int MAX_RETIRE = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // dest_reg[6:0], dest_present[7], src1_reg[14:8], src1_present[15],
    // src2_reg[22:16], src2_present[23], done_tag[29:24]
    input  logic [rrr_pkg::S_DATA_W-1:0]   i_s_axis_tdata,
    // func[1:0]
    input  logic [rrr_pkg::FUNC_W-1:0]     i_s_axis_tuser,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // accepted[0], alloc_tag[6:1], src1_from_rob[7], src1_name[14:8], src1_ready[15],
    // src2_from_rob[16], src2_name[23:17], src2_ready[24], retired_tag[30:25],
    // retired_dest[37:31], retired_has_dest[38]
    output logic [rrr_pkg::M_DATA_W-1:0]   o_m_axis_tdata,
    output logic                           o_m_axis_tlast,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rrr_pkg::CFG_AW-1:0]     paddr,
    input  logic [rrr_pkg::CFG_DW-1:0]     pwdata,
    output logic [rrr_pkg::CFG_DW-1:0]     prdata,
    output logic                           pready
);

    localparam int TAG_AW = $clog2(ROB_DEPTH);
    localparam int OCC_W  = $clog2(ROB_DEPTH + 1);
    localparam int CNT_W  = $clog2(MAX_RETIRE + 1);

    // configuration
    logic [rrr_pkg::RW_W-1:0] r_retire_width;
    logic                     cfg_wr;

    // input and output registers
    logic                 r_in_vld;
    rrr_pkg::t_in_item    r_in;
    rrr_pkg::t_in_item    s_item;
    logic                 s_accept;
    logic                 r_out_vld;
    rrr_pkg::t_out_item   r_out;
    rrr_pkg::t_out_item   res;
    logic                 out_free;

    // reorder buffer state
    logic [ROB_DEPTH-1:0] r_ent_vld;
    logic [ROB_DEPTH-1:0] r_ent_rdy;
    logic [ROB_DEPTH-1:0] r_ent_sup;   // a younger rename took over the destination
    logic [TAG_AW-1:0]    r_head, n_head;
    logic [TAG_AW-1:0]    r_tail, n_tail;
    logic [OCC_W-1:0]     r_occ, n_occ;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [TAG_AW-1:0]    head_inc, tail_inc;

    // execute controls
    logic emit, in_done, alloc, wb_set, commit;
    logic buf_full, dhas, dest_ok;
    logic head_ok, next_ok, commit_ok, commit_last;
    logic [CNT_W-1:0]     retire_limit;
    logic [CNT_W:0]       cnt_inc;
    logic [TAG_AW-1:0]    wb_idx;
    logic                 wb_tag_ok;
    logic                 s1_map, s1_reg_ok, s2_map, s2_reg_ok;

    // map table and entry RAM
    rrr_pkg::t_map_lookup         lookup;
    rrr_pkg::t_map_update         update;
    logic [rrr_pkg::LK_N-1:0]     map_hit;
    logic [TAG_AW-1:0]            map_tag [rrr_pkg::LK_N];
    logic [TAG_AW-1:0]            ent_raddr [1];
    logic [rrr_pkg::REG_W:0]      ent_rdata [1];
    logic [rrr_pkg::REG_W:0]      ent_wdata;
    logic                         ent_has;
    rrr_pkg::t_reg                ent_dest;

    // ---------------------------------------------------------------- APB
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == rrr_pkg::CFG_IDX_RETIRE_WIDTH)
                  ? rrr_pkg::CFG_DW'(r_retire_width) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_retire_width <= rrr_pkg::RETIRE_WIDTH_RST;
        end else if (cfg_wr && (paddr[2] == rrr_pkg::CFG_IDX_RETIRE_WIDTH)) begin
            r_retire_width <= pwdata[rrr_pkg::RW_W-1:0];
        end
    end

    // ------------------------------------------------------- stream unpack
    assign s_item.func         = i_s_axis_tuser;
    assign s_item.dest_reg     = i_s_axis_tdata[6:0];
    assign s_item.dest_present = i_s_axis_tdata[7];
    assign s_item.src1_reg     = i_s_axis_tdata[14:8];
    assign s_item.src1_present = i_s_axis_tdata[15];
    assign s_item.src2_reg     = i_s_axis_tdata[22:16];
    assign s_item.src2_present = i_s_axis_tdata[23];
    assign s_item.done_tag     = i_s_axis_tdata[29:24];

    // Take a new item when the input register is empty or the held one finishes this cycle.
    assign out_free        = !r_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = !r_in_vld || in_done;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // ---------------------------------------------------------- map table
    // Map RAMs are read on the input transfer so their data lines up with r_in.
    assign lookup.load                 = s_accept;
    assign lookup.regs[rrr_pkg::LK_SRC1] = s_item.src1_reg;
    assign lookup.regs[rrr_pkg::LK_SRC2] = s_item.src2_reg;
    assign lookup.regs[rrr_pkg::LK_DEST] = s_item.dest_reg;

    assign update.set     = alloc && dhas;
    assign update.set_reg = r_in.dest_reg;
    // Drop the mapping on commit only if no younger rename took it over.
    assign update.clr     = commit && ent_has && !r_ent_sup[r_head];
    assign update.clr_reg = ent_dest;

    rrr_map #(.ARCH_REGS(ARCH_REGS), .ROB_DEPTH(ROB_DEPTH)) u_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_lookup  (lookup),
        .i_update  (update),
        .i_set_tag (r_tail),
        .o_hit     (map_hit),
        .o_tag     (map_tag)
    );

    // ------------------------------------------------- entry destinations
    // Read at the next head every cycle; a retiring entry was written by an earlier
    // rename, since a writeback must mark it ready first.
    assign ent_raddr[0] = n_head;
    assign ent_wdata    = {dhas, dhas ? r_in.dest_reg : rrr_pkg::t_reg'(0)};
    assign ent_has      = ent_rdata[0][rrr_pkg::REG_W];
    assign ent_dest     = ent_rdata[0][rrr_pkg::REG_W-1:0];

    rrr_ram #(.WIDTH(rrr_pkg::REG_W + 1), .DEPTH(ROB_DEPTH), .N_RD(1)) u_ent_ram (
        .i_clk   (i_clk),
        .i_we    (alloc),
        .i_waddr (r_tail),
        .i_wdata (ent_wdata),
        .i_re    (1'b1),
        .i_raddr (ent_raddr),
        .o_rdata (ent_rdata)
    );

    // ------------------------------------------------------ execute logic
    assign head_inc = (r_head == TAG_AW'(ROB_DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign tail_inc = (r_tail == TAG_AW'(ROB_DEPTH - 1)) ? '0 : r_tail + 1'b1;
    assign buf_full = (r_occ == OCC_W'(ROB_DEPTH));

    assign dest_ok = 32'(r_in.dest_reg) < ARCH_REGS;
    assign dhas    = r_in.dest_present && dest_ok;

    assign s1_map    = r_in.src1_present && map_hit[rrr_pkg::LK_SRC1];
    assign s1_reg_ok = r_in.src1_present && (32'(r_in.src1_reg) < ARCH_REGS);
    assign s2_map    = r_in.src2_present && map_hit[rrr_pkg::LK_SRC2];
    assign s2_reg_ok = r_in.src2_present && (32'(r_in.src2_reg) < ARCH_REGS);

    assign wb_idx    = TAG_AW'(r_in.done_tag);
    assign wb_tag_ok = 32'(r_in.done_tag) < ROB_DEPTH;

    // Clamp the retire width to the commit lanes available.
    assign retire_limit = (32'(r_retire_width) > MAX_RETIRE)
                        ? CNT_W'(MAX_RETIRE) : CNT_W'(r_retire_width);
    assign cnt_inc      = {1'b0, r_cnt} + (CNT_W + 1)'(1);
    assign head_ok      = r_ent_vld[r_head] && r_ent_rdy[r_head];
    assign next_ok      = r_ent_vld[head_inc] && r_ent_rdy[head_inc];
    assign commit_ok    = (r_cnt < retire_limit) && head_ok;
    // Mark last when the width is used up or the following entry cannot commit.
    assign commit_last  = (cnt_inc >= {1'b0, retire_limit}) || !next_ok;

    always_comb begin
        res     = '0;
        emit    = 1'b0;
        in_done = 1'b0;
        alloc   = 1'b0;
        wb_set  = 1'b0;
        commit  = 1'b0;
        if (r_in_vld) begin
            unique case (rrr_pkg::t_func'(r_in.func))
                rrr_pkg::FUNC_RENAME: begin
                    if (out_free) begin
                        emit     = 1'b1;
                        in_done  = 1'b1;
                        res.last = 1'b1;
                        if (!buf_full) begin
                            alloc             = 1'b1;
                            res.accepted      = 1'b1;
                            res.alloc_tag     = rrr_pkg::t_tag'(r_tail);
                            res.src1_from_rob = s1_map;
                            res.src1_name     = s1_map ? rrr_pkg::t_reg'(map_tag[rrr_pkg::LK_SRC1])
                                              : (s1_reg_ok ? r_in.src1_reg : '0);
                            res.src1_ready    = s1_map ? r_ent_rdy[map_tag[rrr_pkg::LK_SRC1]]
                                              : 1'b1;
                            res.src2_from_rob = s2_map;
                            res.src2_name     = s2_map ? rrr_pkg::t_reg'(map_tag[rrr_pkg::LK_SRC2])
                                              : (s2_reg_ok ? r_in.src2_reg : '0);
                            res.src2_ready    = s2_map ? r_ent_rdy[map_tag[rrr_pkg::LK_SRC2]]
                                              : 1'b1;
                        end
                    end
                end
                rrr_pkg::FUNC_WRITEBACK: begin
                    in_done = 1'b1;
                    wb_set  = wb_tag_ok && r_ent_vld[wb_idx];
                end
                rrr_pkg::FUNC_RETIRE: begin
                    if (out_free) begin
                        if (commit_ok) begin
                            commit               = 1'b1;
                            emit                 = 1'b1;
                            in_done              = commit_last;
                            res.retired_tag      = rrr_pkg::t_tag'(r_head);
                            res.retired_dest     = ent_dest;
                            res.retired_has_dest = ent_has;
                            res.last             = commit_last;
                        end else begin
                            in_done = 1'b1;
                        end
                    end
                end
                default: begin
                    in_done = 1'b1;
                end
            endcase
        end
    end

    // Advance pointers and the retire commit count; return both pointers to zero when the last entry leaves.
    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        n_occ  = r_occ;
        if (alloc) begin
            n_tail = tail_inc;
            n_occ  = r_occ + 1'b1;
        end
        if (commit) begin
            if (r_occ == OCC_W'(1)) begin
                n_head = '0;
                n_tail = '0;
            end else begin
                n_head = head_inc;
            end
            n_occ = r_occ - 1'b1;
        end
        if (in_done) begin
            n_cnt = '0;
        end else if (commit) begin
            n_cnt = CNT_W'(cnt_inc);
        end else begin
            n_cnt = r_cnt;
        end
    end

    // ------------------------------------------------------------ registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_vld <= '0;
            r_ent_rdy <= '0;
            r_ent_sup <= '0;
            r_head    <= '0;
            r_tail    <= '0;
            r_occ     <= '0;
            r_cnt     <= '0;
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_occ  <= n_occ;
            r_cnt  <= n_cnt;
            if (alloc) begin
                r_ent_vld[r_tail] <= 1'b1;
                r_ent_rdy[r_tail] <= 1'b0;
                r_ent_sup[r_tail] <= 1'b0;
                if (dhas && map_hit[rrr_pkg::LK_DEST]) begin
                    r_ent_sup[map_tag[rrr_pkg::LK_DEST]] <= 1'b1;
                end
            end
            if (wb_set) begin
                r_ent_rdy[wb_idx] <= 1'b1;
            end
            if (commit) begin
                r_ent_vld[r_head] <= 1'b0;
                r_ent_rdy[r_head] <= 1'b0;
            end
            if (o_s_axis_tready) begin
                r_in_vld <= i_s_axis_tvalid;
            end
            if (emit) begin
                r_out_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload: hold until the next transfer
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in <= s_item;
        end
        if (emit) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tlast  = r_out.last;
    assign o_m_axis_tdata  = {1'b0,
                              r_out.retired_has_dest, r_out.retired_dest, r_out.retired_tag,
                              r_out.src2_ready, r_out.src2_name, r_out.src2_from_rob,
                              r_out.src1_ready, r_out.src1_name, r_out.src1_from_rob,
                              r_out.alloc_tag, r_out.accepted};

    // ----------------------------------------------------------- assertions
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_occ) <= ROB_DEPTH)
        else $error("occupancy beyond buffer depth");

    a_occ_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_ent_vld) == 32'(r_occ))
        else $error("valid entries disagree with occupancy");

    a_empty_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_occ == '0) |-> ((r_head == '0) && (r_tail == '0)))
        else $error("empty buffer with pointers away from zero");

    a_head_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_occ != '0) |-> r_ent_vld[r_head])
        else $error("occupied buffer with free head entry");

endmodule

// ===== tb/sv/register_rename_rob_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for register_rename_rob_core: streams rename, writeback and
// retire commands, predicts map table and reorder buffer behavior, checks every result.
// Depends on rrr_pkg and the RTL of the core; reads nothing else.
module register_rename_rob_core_tb;

    localparam int ROB_N       = 64;   // reorder buffer entries, a power of two
    localparam int NREG        = 67;   // architectural registers
    localparam int RET_MAX     = 8;    // most commits per retire command
    localparam int DRAIN_LIMIT = 5000; // cycles allowed for outstanding results
    localparam int SETTLE      = 16;   // quiet cycles before touching the register

    localparam logic [rrr_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam logic [rrr_pkg::CFG_AW-1:0] RW_ADDR     =
        {rrr_pkg::CFG_IDX_RETIRE_WIDTH, 2'b00};

    // ------------------------------------------------------------------
    // Clock, reset and block signals
    // ------------------------------------------------------------------
    logic                         clk      = 1'b0;
    logic                         rst_n    = 1'b0;
    logic                         s_tvalid = 1'b0;
    logic [rrr_pkg::S_DATA_W-1:0] s_tdata  = '0;
    logic [rrr_pkg::FUNC_W-1:0]   s_tuser  = '0;
    logic                         m_tready = 1'b0;
    logic                         psel     = 1'b0;
    logic                         penable  = 1'b0;
    logic                         pwrite   = 1'b0;
    logic [rrr_pkg::CFG_AW-1:0]   paddr    = '0;
    logic [rrr_pkg::CFG_DW-1:0]   pwdata   = '0;

    logic                         o_s_tready;
    logic                         o_m_tvalid;
    logic [rrr_pkg::M_DATA_W-1:0] o_m_tdata;
    logic                         o_m_tlast;
    logic [rrr_pkg::CFG_DW-1:0]   prdata;
    logic                         pready;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    register_rename_rob_core u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_tready),
        // dest_reg[6:0], dest_present[7], src1_reg[14:8], src1_present[15],
        // src2_reg[22:16], src2_present[23], done_tag[29:24]
        .i_s_axis_tdata  (s_tdata),
        // func[1:0]
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (o_m_tvalid),
        .i_m_axis_tready (m_tready),
        // accepted[0], alloc_tag[6:1], src1_from_rob[7], src1_name[14:8], src1_ready[15],
        // src2_from_rob[16], src2_name[23:17], src2_ready[24], retired_tag[30:25],
        // retired_dest[37:31], retired_has_dest[38]
        .o_m_axis_tdata  (o_m_tdata),
        .o_m_axis_tlast  (o_m_tlast),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the rename state
    // ------------------------------------------------------------------
    logic                     map_live    [NREG];
    rrr_pkg::t_tag            map_ptr     [NREG];
    logic                     rob_busy    [ROB_N];
    logic                     rob_done    [ROB_N];
    rrr_pkg::t_reg            rob_dst     [ROB_N];
    logic                     rob_has_dst [ROB_N];
    rrr_pkg::t_tag            sh_head;
    rrr_pkg::t_tag            sh_tail;
    int                       rob_count;
    logic [rrr_pkg::RW_W-1:0] cfg_retire_w;

    rrr_pkg::t_in_item  rob_cmds[$];     // commands waiting for the driver
    rrr_pkg::t_out_item due_results[$];  // results the block still owes, oldest first

    logic               no_idle = 1'b0;  // burst mode: neither side inserts gaps
    int                 bad_count = 0;
    int                 result_idx = 0;
    int                 in_gap = 0;
    int                 out_wait = 0;
    logic               in_busy;
    rrr_pkg::t_in_item  cur_cmd;
    rrr_pkg::t_out_item want_res;

    // Look a source up in the map table: {from_rob, name, ready}.
    function automatic logic [8:0] map_src(input rrr_pkg::t_reg r, input logic present);
        if (!present || r >= NREG)
            return {1'b0, 7'd0, 1'b1};
        if (map_live[r])
            return {1'b1, 1'b0, map_ptr[r], rob_done[map_ptr[r]]};
        return {1'b0, r, 1'b1};
    endfunction

    // Apply one accepted command to the shadow state and queue its results.
    task automatic advance_rob(input rrr_pkg::t_in_item it);
        rrr_pkg::t_out_item r;
        rrr_pkg::t_out_item batch [RET_MAX];
        logic               dhas;
        rrr_pkg::t_tag      h;
        int                 n;
        int                 lim;
        r = '0;
        n = 0;
        if (it.func == rrr_pkg::FUNC_RENAME) begin
            r.last = 1'b1;
            // a full buffer refuses the command and leaves the state alone
            if (rob_count < ROB_N) begin
                dhas = it.dest_present && (it.dest_reg < NREG);
                // sources see the map before this destination lands in it
                {r.src1_from_rob, r.src1_name, r.src1_ready} =
                    map_src(it.src1_reg, it.src1_present);
                {r.src2_from_rob, r.src2_name, r.src2_ready} =
                    map_src(it.src2_reg, it.src2_present);
                rob_busy[sh_tail]    = 1'b1;
                rob_done[sh_tail]    = 1'b0;
                rob_dst[sh_tail]     = dhas ? it.dest_reg : '0;
                rob_has_dst[sh_tail] = dhas;
                if (dhas) begin
                    map_live[it.dest_reg] = 1'b1;
                    map_ptr[it.dest_reg]  = sh_tail;
                end
                r.accepted  = 1'b1;
                r.alloc_tag = sh_tail;
                sh_tail     = sh_tail + 1'b1;  // wraps at the buffer depth
                rob_count++;
            end
            due_results.insert(due_results.size(), r);
        end else if (it.func == rrr_pkg::FUNC_WRITEBACK) begin
            // free entries ignore writebacks
            if (rob_busy[it.done_tag])
                rob_done[it.done_tag] = 1'b1;
        end else if (it.func == rrr_pkg::FUNC_RETIRE) begin
            lim = (cfg_retire_w > RET_MAX) ? RET_MAX : int'(cfg_retire_w);
            while (n < lim && rob_busy[sh_head] && rob_done[sh_head]) begin
                h = sh_head;
                // drop the mapping only if no younger writer took the register
                if (rob_has_dst[h] && map_live[rob_dst[h]] && map_ptr[rob_dst[h]] == h) begin
                    map_live[rob_dst[h]] = 1'b0;
                    map_ptr[rob_dst[h]]  = '0;
                end
                batch[n]                  = '0;
                batch[n].retired_tag      = h;
                batch[n].retired_dest     = rob_dst[h];
                batch[n].retired_has_dest = rob_has_dst[h];
                rob_busy[h] = 1'b0;
                rob_done[h] = 1'b0;
                sh_head     = h + 1'b1;
                rob_count--;
                n++;
            end
            if (rob_count == 0) begin
                sh_head = '0;
                sh_tail = '0;
            end
            for (int k = 0; k < n; k++) begin
                batch[k].last = (k == n - 1);
                due_results.insert(due_results.size(), batch[k]);
            end
        end
    endtask

    task automatic report_mismatch(input string msg);
        if (bad_count < 50)
            $display("[%0t] ERROR: %s", $time, msg);
        bad_count++;
    endtask

    task automatic check_field(input string fld, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("result %0d field %s: got %0h, want %0h",
                                      result_idx, fld, got, want));
    endtask

    // ------------------------------------------------------------------
    // Driver: present one command per transfer, predict it on acceptance
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            in_gap   = 0;
        end else begin
            if (s_tvalid && o_s_tready) begin
                advance_rob(cur_cmd);
                in_busy = 1'b0;
            end else begin
                in_busy = s_tvalid;
            end
            if (!in_busy) begin
                if (in_gap > 0) begin
                    in_gap--;
                    s_tvalid <= 1'b0;
                end else if (rob_cmds.size() != 0) begin
                    cur_cmd = rob_cmds.pop_front();
                    s_tdata <= {2'b00, cur_cmd.done_tag,
                                cur_cmd.src2_present, cur_cmd.src2_reg,
                                cur_cmd.src1_present, cur_cmd.src1_reg,
                                cur_cmd.dest_present, cur_cmd.dest_reg};
                    s_tuser  <= cur_cmd.func;
                    s_tvalid <= 1'b1;
                    // gap taken after this command is transferred
                    in_gap = no_idle ? 0 : $urandom_range(0, 4);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each result transfer with the oldest due result
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
            out_wait = 0;
        end else begin
            if (o_m_tvalid && m_tready) begin
                if (due_results.size() == 0) begin
                    report_mismatch($sformatf("result with nothing due: tdata %h tlast %b",
                                              o_m_tdata, o_m_tlast));
                end else begin
                    want_res = due_results.pop_front();
                    check_field("accepted",         int'(o_m_tdata[0]),
                                int'(want_res.accepted));
                    check_field("alloc_tag",        int'(o_m_tdata[6:1]),
                                int'(want_res.alloc_tag));
                    check_field("src1_from_rob",    int'(o_m_tdata[7]),
                                int'(want_res.src1_from_rob));
                    check_field("src1_name",        int'(o_m_tdata[14:8]),
                                int'(want_res.src1_name));
                    check_field("src1_ready",       int'(o_m_tdata[15]),
                                int'(want_res.src1_ready));
                    check_field("src2_from_rob",    int'(o_m_tdata[16]),
                                int'(want_res.src2_from_rob));
                    check_field("src2_name",        int'(o_m_tdata[23:17]),
                                int'(want_res.src2_name));
                    check_field("src2_ready",       int'(o_m_tdata[24]),
                                int'(want_res.src2_ready));
                    check_field("retired_tag",      int'(o_m_tdata[30:25]),
                                int'(want_res.retired_tag));
                    check_field("retired_dest",     int'(o_m_tdata[37:31]),
                                int'(want_res.retired_dest));
                    check_field("retired_has_dest", int'(o_m_tdata[38]),
                                int'(want_res.retired_has_dest));
                    check_field("last",             int'(o_m_tlast),
                                int'(want_res.last));
                end
                result_idx++;
                out_wait = no_idle ? 0 : $urandom_range(0, 4);
            end
            // stall the result side for the drawn number of cycles
            if (out_wait > 0) begin
                out_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Hold the command queue short so generated writebacks see fresh state.
    task automatic feed(input rrr_pkg::t_in_item it);
        while (rob_cmds.size() >= 2)
            @(negedge clk);
        rob_cmds.insert(rob_cmds.size(), it);
    endtask

    function automatic rrr_pkg::t_in_item mk_cmd(input logic [rrr_pkg::FUNC_W-1:0] f,
                                                 input rrr_pkg::t_reg d, input logic dp,
                                                 input rrr_pkg::t_reg s1, input logic s1p,
                                                 input rrr_pkg::t_reg s2, input logic s2p,
                                                 input rrr_pkg::t_tag tag);
        rrr_pkg::t_in_item it;
        it.func         = f;
        it.dest_reg     = d;
        it.dest_present = dp;
        it.src1_reg     = s1;
        it.src1_present = s1p;
        it.src2_reg     = s2;
        it.src2_present = s2p;
        it.done_tag     = tag;
        return it;
    endfunction

    // Favor a few registers so renames chain on each other; keep some out of range.
    function automatic rrr_pkg::t_reg pick_reg();
        int p;
        p = $urandom_range(0, 99);
        if (p < 40) return rrr_pkg::t_reg'($urandom_range(0, 5));
        if (p < 55) return rrr_pkg::t_reg'($urandom_range(60, 66));
        if (p < 65) return rrr_pkg::t_reg'($urandom_range(67, 127));
        return rrr_pkg::t_reg'($urandom_range(0, 66));
    endfunction

    // Wait until every command is in and every due result is out, then let the
    // block settle. Anything still owed after the limit is a failure.
    task automatic drain_results();
        int spin;
        spin = 0;
        while ((rob_cmds.size() != 0 || s_tvalid || due_results.size() != 0)
               && spin < DRAIN_LIMIT) begin
            @(negedge clk);
            spin++;
        end
        repeat (SETTLE) @(negedge clk);
        if (due_results.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", due_results.size()));
            due_results.delete();
        end
    endtask

    // Register write (setup, then access), landing at the edge that ends the access cycle,
    // then a read (setup, then access) that must return the written width.
    task automatic set_retire_width(input logic [rrr_pkg::RW_W-1:0] w);
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= RW_ADDR;
        pwdata  <= {28'($urandom), w};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (!pready || prdata != rrr_pkg::CFG_DW'(w))
            report_mismatch($sformatf("retire_width read back %0h, want %0h", prdata, w));
        psel    <= 1'b0;
        penable <= 1'b0;
        cfg_retire_w = w;
    endtask

    // ------------------------------------------------------------------
    // Run control
    // ------------------------------------------------------------------
    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial begin
        rrr_pkg::t_in_item        it;
        logic [rrr_pkg::RW_W-1:0] phase_w [6];
        int                       sel;
        int                       off;
        phase_w[0] = 4'd0;
        phase_w[1] = 4'd1;
        phase_w[2] = 4'd3;
        phase_w[3] = 4'd8;
        phase_w[4] = 4'd15;
        phase_w[5] = 4'($urandom_range(1, 8));

        for (int r = 0; r < NREG; r++) begin
            map_live[r] = 1'b0;
            map_ptr[r]  = '0;
        end
        for (int e = 0; e < ROB_N; e++) begin
            rob_busy[e]    = 1'b0;
            rob_done[e]    = 1'b0;
            rob_dst[e]     = '0;
            rob_has_dst[e] = 1'b0;
        end
        sh_head      = '0;
        sh_tail      = '0;
        rob_count    = 0;
        cfg_retire_w = rrr_pkg::RETIRE_WIDTH_RST;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: dependencies, absent and out-of-range registers, stale
        // writebacks, retire with an unready head, unknown function code.
        feed(mk_cmd(rrr_pkg::FUNC_RENAME,    7'd0,   1'b1, 7'd5,   1'b0, 7'd9,  1'b0, '0));
        feed(mk_cmd(rrr_pkg::FUNC_RENAME,    7'd66,  1'b1, 7'd0,   1'b1, 7'd66, 1'b1, '0));
        feed(mk_cmd(rrr_pkg::FUNC_RENAME,    7'd100, 1'b1, 7'd127, 1'b1, 7'd66, 1'b1, '0));
        feed(mk_cmd(rrr_pkg::FUNC_RENAME,    7'd127, 1'b0, 7'd67,  1'b0, 7'd0,  1'b0, '0));
        feed(mk_cmd(rrr_pkg::FUNC_WRITEBACK, '0,     1'b0, '0,     1'b0, '0,    1'b0, 6'd0));
        feed(mk_cmd(rrr_pkg::FUNC_WRITEBACK, '0,     1'b0, '0,     1'b0, '0,    1'b0, 6'd63));
        feed(mk_cmd(rrr_pkg::FUNC_WRITEBACK, '0,     1'b0, '0,     1'b0, '0,    1'b0, 6'd0));
        feed(mk_cmd(rrr_pkg::FUNC_RENAME,    7'd0,   1'b1, 7'd0,   1'b1, 7'd66, 1'b1, '0));
        feed(mk_cmd(rrr_pkg::FUNC_RETIRE,    '0,     1'b0, '0,     1'b0, '0,    1'b0, '0));
        feed(mk_cmd(rrr_pkg::FUNC_RETIRE,    '0,     1'b0, '0,     1'b0, '0,    1'b0, '0));
        feed(rrr_pkg::t_in_item'({FUNC_UNUSED, 30'($urandom)}));
        feed(mk_cmd(rrr_pkg::FUNC_WRITEBACK, '0,     1'b0, '0,     1'b0, '0,    1'b0, 6'd1));
        feed(mk_cmd(rrr_pkg::FUNC_WRITEBACK, '0,     1'b0, '0,     1'b0, '0,    1'b0, 6'd2));
        feed(mk_cmd(rrr_pkg::FUNC_WRITEBACK, '0,     1'b0, '0,     1'b0, '0,    1'b0, 6'd4));
        feed(mk_cmd(rrr_pkg::FUNC_RETIRE,    '0,     1'b0, '0,     1'b0, '0,    1'b0, '0));
        feed(mk_cmd(rrr_pkg::FUNC_RENAME,    7'd66,  1'b1, 7'd66,  1'b1, 7'd0,  1'b1, '0));
        feed(mk_cmd(rrr_pkg::FUNC_WRITEBACK, '0,     1'b0, '0,     1'b0, '0,    1'b0, 6'd3));
        drain_results();
        set_retire_width(4'd8);
        feed(mk_cmd(rrr_pkg::FUNC_RETIRE,    '0,     1'b0, '0,     1'b0, '0,    1'b0, '0));
        feed(mk_cmd(rrr_pkg::FUNC_WRITEBACK, '0,     1'b0, '0,     1'b0, '0,    1'b0, 6'd5));
        feed(mk_cmd(rrr_pkg::FUNC_RETIRE,    '0,     1'b0, '0,     1'b0, '0,    1'b0, '0));
        feed(mk_cmd(rrr_pkg::FUNC_RENAME,    7'd1,   1'b1, 7'd66,  1'b1, 7'd0,  1'b1, '0));
        feed(mk_cmd(rrr_pkg::FUNC_WRITEBACK, '0,     1'b0, '0,     1'b0, '0,    1'b0, 6'd0));
        feed(mk_cmd(rrr_pkg::FUNC_RETIRE,    '0,     1'b0, '0,     1'b0, '0,    1'b0, '0));

        // Fill the buffer past full, complete every entry out of order, then
        // drain with a width above the retire limit.
        for (int n = 0; n < ROB_N + 2; n++) begin
            it              = rrr_pkg::t_in_item'($urandom);
            it.func         = rrr_pkg::FUNC_RENAME;
            it.dest_reg     = pick_reg();
            it.src1_reg     = pick_reg();
            it.src2_reg     = pick_reg();
            feed(it);
        end
        for (int n = 0; n < ROB_N; n++) begin
            it          = rrr_pkg::t_in_item'($urandom);
            it.func     = rrr_pkg::FUNC_WRITEBACK;
            it.done_tag = rrr_pkg::t_tag'(ROB_N - 1 - n);
            feed(it);
        end
        drain_results();
        set_retire_width(4'd15);
        for (int n = 0; n < ROB_N / RET_MAX + 1; n++) begin
            it      = rrr_pkg::t_in_item'($urandom);
            it.func = rrr_pkg::FUNC_RETIRE;
            feed(it);
        end

        // Random phases, one retire width each; every third runs without gaps.
        for (int ph = 0; ph < 6; ph++) begin
            drain_results();
            set_retire_width(phase_w[ph]);
            no_idle = (ph % 3 == 2);
            for (int n = 0; n < 25; n++) begin
                // stop sending until the block has caught up, once per phase
                if (n == 12)
                    drain_results();
                it  = rrr_pkg::t_in_item'($urandom);
                sel = $urandom_range(0, 99);
                if (sel < 45) begin
                    it.func         = rrr_pkg::FUNC_RENAME;
                    it.dest_reg     = pick_reg();
                    it.src1_reg     = pick_reg();
                    it.src2_reg     = pick_reg();
                    it.dest_present = ($urandom_range(0, 7) != 0);
                    it.src1_present = ($urandom_range(0, 7) != 0);
                    it.src2_present = ($urandom_range(0, 7) != 0);
                end else if (sel < 78) begin
                    it.func = rrr_pkg::FUNC_WRITEBACK;
                    // mostly target live entries, near the head half the time
                    if (rob_count > 0 && $urandom_range(0, 4) != 0) begin
                        if ($urandom_range(0, 1) != 0)
                            off = $urandom_range(0, (rob_count > 8) ? 7 : rob_count - 1);
                        else
                            off = $urandom_range(0, rob_count - 1);
                        it.done_tag = sh_head + rrr_pkg::t_tag'(off);
                    end
                end else if (sel < 97) begin
                    it.func = rrr_pkg::FUNC_RETIRE;
                end else begin
                    it.func = FUNC_UNUSED;
                end
                feed(it);
            end
        end
        no_idle = 1'b0;

        drain_results();
        if (bad_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
